### rtl/assert_macros.svh
// Assertion macros shared by the triangle slope classifier RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

### rtl/tsc_pkg.sv
// Shared constants and types for the triangle slope classifier.
// No dependencies; imported by every tsc module.
package tsc_pkg;

   localparam int FRONT_LAT = 8;              // stages from item entry to sum of squares
   localparam int DIFF_LIM  = 30;             // widest vertex difference magnitude kept
   localparam int MAG_BITS  = 30;             // normalized component magnitude
   localparam int MAG_TOP   = MAG_BITS - 1;   // bit the largest magnitude is aligned to
   localparam int SQ_BITS   = 2 * MAG_BITS;
   localparam int SUM_BITS  = SQ_BITS + 2;
   localparam int ROOT_BITS = SUM_BITS / 2;
   localparam int POS_BITS  = 6;

   localparam int THR_BITS = 16;
   localparam int THR_FRAC = THR_BITS - 1;
   localparam logic signed [THR_BITS-1:0] THR_RESET = 16'sd28378;

   localparam int C3_CHUNK  = 8;
   localparam int C3_CHUNKS = FRONT_LAT - 1;
   localparam int C3_BITS   = C3_CHUNK * C3_CHUNKS;

   typedef struct packed {
      logic       zero;
      logic [2:0] neg;
   } face_flags_type;

endpackage

### rtl/tsc_front.sv
// Front pipeline: edge vectors, cross product, magnitude alignment, sum of squares.
// Depends on tsc_pkg.
module tsc_front
   import tsc_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] va [3],
   input  logic signed [COORD_BITS-1:0] vb [3],
   input  logic signed [COORD_BITS-1:0] vq [3],
   output logic                         out_valid,
   output face_flags_type               out_flags,
   output logic [MAG_BITS-1:0]          out_mag [3],
   output logic [SUM_BITS-1:0]          out_sum
);

   localparam int LIM = (COORD_BITS > DIFF_LIM) ? DIFF_LIM : COORD_BITS;
   localparam int DS  = COORD_BITS - LIM;
   localparam int DW  = LIM + 1;
   localparam int PW  = 2 * DW;
   localparam int CW  = PW + 1;
   localparam int XW  = (CW > MAG_BITS) ? CW : MAG_BITS;

   logic [FRONT_LAT-1:0] vld_ff;

   logic signed [COORD_BITS:0] raw1 [3];
   logic signed [COORD_BITS:0] raw2 [3];
   logic [COORD_BITS:0]        am1 [3];
   logic [COORD_BITS:0]        am2 [3];
   logic [COORD_BITS:0]        tm1 [3];
   logic [COORD_BITS:0]        tm2 [3];
   logic signed [DW-1:0]       d1_in [3];
   logic signed [DW-1:0]       d2_in [3];
   logic signed [DW-1:0]       d1_ff [3];
   logic signed [DW-1:0]       d2_ff [3];

   logic signed [PW-1:0]       prod_ff [6];
   logic signed [CW-1:0]       cr_ff [3];

   logic [CW-1:0]              mag4_in [3];
   logic [CW-1:0]              mag4_ff [3];
   logic [2:0]                 neg4_ff;

   logic [CW-1:0]              orv;
   logic [POS_BITS-1:0]        pos_in;
   logic [POS_BITS-1:0]        pos5_ff;
   logic [CW-1:0]              mag5_ff [3];
   logic [2:0]                 neg5_ff;
   logic                       zero5_ff;

   logic [XW-1:0]              ext [3];
   logic [XW-1:0]              sh [3];
   logic [MAG_BITS-1:0]        mg6_ff [3];
   face_flags_type             flags6_ff;

   logic [MAG_BITS-1:0]        mg7_ff [3];
   logic [SQ_BITS-1:0]         sq7_ff [3];
   face_flags_type             flags7_ff;

   logic [MAG_BITS-1:0]        mg8_ff [3];
   logic [SUM_BITS-1:0]        sum8_ff;
   face_flags_type             flags8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FRONT_LAT-2:0], in_valid};
      end
   end

   // Edge vectors, truncated toward zero when coordinates are wide.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         raw1[i] = va[i] - vb[i];
         raw2[i] = va[i] - vq[i];
         am1[i]  = raw1[i][COORD_BITS] ? -raw1[i] : raw1[i];
         am2[i]  = raw2[i][COORD_BITS] ? -raw2[i] : raw2[i];
         tm1[i]  = am1[i] >> DS;
         tm2[i]  = am2[i] >> DS;
         d1_in[i] = raw1[i][COORD_BITS] ? -tm1[i][DW-1:0] : tm1[i][DW-1:0];
         d2_in[i] = raw2[i][COORD_BITS] ? -tm2[i][DW-1:0] : tm2[i][DW-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag4_in[i] = cr_ff[i][CW-1] ? -cr_ff[i] : cr_ff[i];
      end
   end

   // The largest magnitude and the OR of all three share their leading one.
   always_comb begin
      orv    = mag4_ff[0] | mag4_ff[1] | mag4_ff[2];
      pos_in = '0;
      for (int b = 0; b < CW; b++) begin
         if (orv[b]) begin
            pos_in = POS_BITS'(b);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ext[i] = XW'(mag5_ff[i]);
         if (pos5_ff >= POS_BITS'(MAG_TOP)) begin
            sh[i] = ext[i] >> (pos5_ff - POS_BITS'(MAG_TOP));
         end else begin
            sh[i] = ext[i] << (POS_BITS'(MAG_TOP) - pos5_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= d1_in[i];
            d2_ff[i] <= d2_in[i];
         end
         prod_ff[0] <= d1_ff[1] * d2_ff[2];
         prod_ff[1] <= d1_ff[2] * d2_ff[1];
         prod_ff[2] <= d1_ff[2] * d2_ff[0];
         prod_ff[3] <= d1_ff[0] * d2_ff[2];
         prod_ff[4] <= d1_ff[0] * d2_ff[1];
         prod_ff[5] <= d1_ff[1] * d2_ff[0];
         cr_ff[0] <= prod_ff[0] - prod_ff[1];
         cr_ff[1] <= prod_ff[2] - prod_ff[3];
         cr_ff[2] <= prod_ff[4] - prod_ff[5];
         for (int i = 0; i < 3; i++) begin
            mag4_ff[i] <= mag4_in[i];
            neg4_ff[i] <= cr_ff[i][CW-1];
            mag5_ff[i] <= mag4_ff[i];
            mg6_ff[i]  <= sh[i][MAG_BITS-1:0];
            mg7_ff[i]  <= mg6_ff[i];
            sq7_ff[i]  <= SQ_BITS'(mg6_ff[i]) * SQ_BITS'(mg6_ff[i]);
            mg8_ff[i]  <= mg7_ff[i];
         end
         neg5_ff   <= neg4_ff;
         zero5_ff  <= (orv == '0);
         pos5_ff   <= pos_in;
         flags6_ff <= '{zero: zero5_ff, neg: neg5_ff};
         flags7_ff <= flags6_ff;
         flags8_ff <= flags7_ff;
         sum8_ff   <= SUM_BITS'(sq7_ff[0]) + SUM_BITS'(sq7_ff[1]) + SUM_BITS'(sq7_ff[2]);
      end
   end

   assign out_valid = vld_ff[FRONT_LAT-1];
   assign out_flags = flags8_ff;
   assign out_sum   = sum8_ff;
   assign out_mag   = mg8_ff;

endmodule

### rtl/tsc_div3.sv
// Centroid: vertex sum plus one, divided by three with floor, 8 bits per stage.
// Depends on tsc_pkg; latency matches tsc_front.
module tsc_div3
   import tsc_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [COORD_BITS-1:0] va [3],
   input  logic signed [COORD_BITS-1:0] vb [3],
   input  logic signed [COORD_BITS-1:0] vq [3],
   output logic signed [COORD_BITS-1:0] center [3]
);

   localparam int SW = COORD_BITS + 4;
   // Bias keeps the dividend positive; it adds a multiple of 2^COORD_BITS to the quotient.
   localparam logic signed [SW-1:0] BIAS = SW'((64'd3 << (COORD_BITS + 1)) + 64'd1);

   logic signed [SW-1:0] s [3];
   logic [C3_BITS-1:0]   work0_ff [3];
   logic [C3_BITS-1:0]   work_ff [3][C3_CHUNKS];
   logic [1:0]           rem_ff [3][C3_CHUNKS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s[i] = va[i] + vb[i] + vq[i] + BIAS;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            work0_ff[i] <= {{(C3_BITS-SW){1'b0}}, s[i]};
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_coord
      for (genvar j = 0; j < C3_CHUNKS; j++) begin : g_chunk
         logic [C3_BITS-1:0]  w_prev;
         logic [1:0]          r_prev;
         logic [1:0]          r_in;
         logic [C3_CHUNK-1:0] qbits;
         logic [2:0]          part;

         if (j == 0) begin : g_first
            assign w_prev = work0_ff[c];
            assign r_prev = 2'b00;
         end else begin : g_next
            assign w_prev = work_ff[c][j-1];
            assign r_prev = rem_ff[c][j-1];
         end

         always_comb begin
            r_in  = r_prev;
            qbits = '0;
            part  = '0;
            for (int k = 0; k < C3_CHUNK; k++) begin
               part = {r_in, w_prev[C3_BITS-1-k]};
               if (part >= 3'd3) begin
                  qbits[C3_CHUNK-1-k] = 1'b1;
                  r_in = 2'(part - 3'd3);
               end else begin
                  r_in = part[1:0];
               end
            end
         end

         // Shift the consumed dividend bits out, the quotient bits in.
         always_ff @(posedge clock) begin
            if (en) begin
               work_ff[c][j] <= {w_prev[C3_BITS-C3_CHUNK-1:0], qbits};
               rem_ff[c][j]  <= r_in;
            end
         end
      end

      assign center[c] = work_ff[c][C3_CHUNKS-1][COORD_BITS-1:0];
   end

endmodule

### rtl/tsc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on tsc_pkg; carries a side vector alongside.
module tsc_sqrt
   import tsc_pkg::*;
#(
   parameter int SIDE_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [SUM_BITS-1:0]  in_sum,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [ROOT_BITS-1:0] out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int N  = ROOT_BITS;
   localparam int RW = ROOT_BITS + 2;

   logic [N-1:0]         vld_ff;
   logic [SUM_BITS-1:0]  x_ff [N];
   logic [RW-1:0]        rem_ff [N];
   logic [ROOT_BITS-1:0] root_ff [N];
   logic [SIDE_W-1:0]    side_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [SUM_BITS-1:0]  x_prev;
      logic [RW-1:0]        rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [SIDE_W-1:0]    side_prev;
      logic [RW+1:0]        part;
      logic [RW+1:0]        trial;
      logic [RW-1:0]        rem_in;
      logic [ROOT_BITS-1:0] root_in;

      if (j == 0) begin : g_first
         assign x_prev    = in_sum;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign x_prev    = x_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_comb begin
         part  = {rem_prev, x_prev[SUM_BITS-1 -: 2]};
         trial = (RW+2)'({root_prev, 2'b01});
         if (part >= trial) begin
            rem_in  = RW'(part - trial);
            root_in = {root_prev[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = part[RW-1:0];
            root_in = {root_prev[ROOT_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[j]    <= {x_prev[SUM_BITS-3:0], 2'b00};
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

### rtl/tsc_ndiv.sv
// Pipelined rounded division of three magnitudes by the vector length, one bit per stage.
// Depends on tsc_pkg; carries a side vector alongside.
module tsc_ndiv
   import tsc_pkg::*;
#(
   parameter int NORMAL_BITS = 16,
   parameter int SIDE_W      = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [MAG_BITS-1:0]    in_mag [3],
   input  logic [ROOT_BITS-1:0]   in_root,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output logic [NORMAL_BITS-1:0] out_quo [3],
   output logic [SIDE_W-1:0]      out_side
);

   localparam int NB = NORMAL_BITS;
   localparam int NW = MAG_BITS + NB;
   localparam int NS = NB + 1;

   logic [NS-1:0]        vld_ff;
   logic [NW-1:0]        num0_ff [3];
   logic [ROOT_BITS-1:0] len0_ff;
   logic [SIDE_W-1:0]    side0_ff;
   logic [ROOT_BITS-1:0] rem_ff [3][NB];
   logic [NB-1:0]        work_ff [3][NB];
   logic [ROOT_BITS-1:0] len_ff [NB];
   logic [SIDE_W-1:0]    side_ff [NB];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   // Numerator with half the divisor added for round to nearest.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            num0_ff[i] <= (NW'(in_mag[i]) << (NB - 1)) + NW'(in_root >> 1);
         end
         len0_ff  <= in_root;
         side0_ff <= in_side;
      end
   end

   for (genvar j = 0; j < NB; j++) begin : g_stage
      logic [ROOT_BITS-1:0] rem_prev [3];
      logic [NB-1:0]        work_prev [3];
      logic [ROOT_BITS-1:0] len_prev;
      logic [SIDE_W-1:0]    side_prev;
      logic [ROOT_BITS:0]   part [3];
      logic [ROOT_BITS-1:0] rem_in [3];
      logic [NB-1:0]        work_in [3];

      if (j == 0) begin : g_first
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_prev[i]  = ROOT_BITS'(num0_ff[i][NW-1:NB]);
            assign work_prev[i] = num0_ff[i][NB-1:0];
         end
         assign len_prev  = len0_ff;
         assign side_prev = side0_ff;
      end else begin : g_next
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_prev[i]  = rem_ff[i][j-1];
            assign work_prev[i] = work_ff[i][j-1];
         end
         assign len_prev  = len_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            part[i] = {rem_prev[i], work_prev[i][NB-1]};
            if (part[i] >= (ROOT_BITS+1)'(len_prev)) begin
               rem_in[i]  = ROOT_BITS'(part[i] - (ROOT_BITS+1)'(len_prev));
               work_in[i] = {work_prev[i][NB-2:0], 1'b1};
            end else begin
               rem_in[i]  = part[i][ROOT_BITS-1:0];
               work_in[i] = {work_prev[i][NB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[i][j]  <= rem_in[i];
               work_ff[i][j] <= work_in[i];
            end
            len_ff[j]  <= len_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_out
      assign out_quo[i] = work_ff[i][NB-1];
   end
   assign out_valid = vld_ff[NS-1];
   assign out_side  = side_ff[NB-1];

endmodule

### rtl/triangle_slope_classifier.sv
// Triangle slope classifier: takes one face per cycle while req_stall is low and returns
// its centroid, unit normal and a traversable flag; faces flagged as non-triangles are taken
// and dropped. It has 8 front stages (cross product, alignment, sum of squares), 31
// square-root stages at one root bit each, NORMAL_BITS + 1 divider stages (a numerator
// register, then one quotient bit each) and the output register. The whole pipeline
// advances together and holds while a result sits in the output register under rsp_stall.
// Depends on tsc_pkg, tsc_front, tsc_div3, tsc_sqrt, tsc_ndiv and assert_macros.svh.
`include "assert_macros.svh"

module triangle_slope_classifier
   import tsc_pkg::*;
#(
   parameter int COORD_BITS  = 24,
   parameter int NORMAL_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_is_triangle,
   input  logic signed [COORD_BITS-1:0]  req_ax,
   input  logic signed [COORD_BITS-1:0]  req_ay,
   input  logic signed [COORD_BITS-1:0]  req_az,
   input  logic signed [COORD_BITS-1:0]  req_bx,
   input  logic signed [COORD_BITS-1:0]  req_by_coord,
   input  logic signed [COORD_BITS-1:0]  req_bz,
   input  logic signed [COORD_BITS-1:0]  req_qx,
   input  logic signed [COORD_BITS-1:0]  req_qy,
   input  logic signed [COORD_BITS-1:0]  req_qz,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS-1:0]  rsp_center_x,
   output logic signed [COORD_BITS-1:0]  rsp_center_y,
   output logic signed [COORD_BITS-1:0]  rsp_center_z,
   output logic signed [NORMAL_BITS-1:0] rsp_nrm_x,
   output logic signed [NORMAL_BITS-1:0] rsp_nrm_y,
   output logic signed [NORMAL_BITS-1:0] rsp_nrm_z,
   output logic                          rsp_traversable,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic signed [THR_BITS-1:0]    csr_cos_threshold
);

   localparam int FLG_W   = $bits(face_flags_type);
   localparam int CEN_W   = 3 * COORD_BITS;
   localparam int SQ_SIDE = FLG_W + 3 * MAG_BITS + CEN_W;
   localparam int DV_SIDE = FLG_W + CEN_W;
   localparam logic [NORMAL_BITS-1:0] NTOP = NORMAL_BITS'(1) << (NORMAL_BITS - 1);
   localparam logic [NORMAL_BITS-1:0] NMAX = NTOP - 1'b1;
   localparam int CMP_W = NORMAL_BITS + THR_FRAC;

   logic                          en;
   logic signed [THR_BITS-1:0]    thr_ff;

   logic signed [COORD_BITS-1:0]  va [3];
   logic signed [COORD_BITS-1:0]  vb [3];
   logic signed [COORD_BITS-1:0]  vq [3];
   logic signed [COORD_BITS-1:0]  center [3];

   logic                          fr_valid;
   face_flags_type                fr_flags;
   logic [MAG_BITS-1:0]           fr_mag [3];
   logic [SUM_BITS-1:0]           fr_sum;

   logic [SQ_SIDE-1:0]            sq_side_in;
   logic                          sq_valid;
   logic [ROOT_BITS-1:0]          sq_root;
   logic [SQ_SIDE-1:0]            sq_side;
   logic [MAG_BITS-1:0]           sq_mag [3];

   logic                          div_valid;
   logic [NORMAL_BITS-1:0]        div_quo [3];
   logic [DV_SIDE-1:0]            div_side;
   face_flags_type                div_flags;

   logic signed [NORMAL_BITS-1:0] nrm_in [3];
   logic signed [CMP_W-1:0]       lhs;
   logic signed [CMP_W-1:0]       rhs;
   logic                          trav_in;

   logic                          rsp_valid_ff;
   logic [CEN_W-1:0]              cen_ff;
   logic signed [NORMAL_BITS-1:0] nrm_ff [3];
   logic                          trav_ff;

   // Advance everything unless the output register is held.
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_cos_threshold;
      end
   end

   assign va[0] = req_ax;
   assign va[1] = req_ay;
   assign va[2] = req_az;
   assign vb[0] = req_bx;
   assign vb[1] = req_by_coord;
   assign vb[2] = req_bz;
   assign vq[0] = req_qx;
   assign vq[1] = req_qy;
   assign vq[2] = req_qz;

   tsc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid && req_is_triangle),
      .va        (va),
      .vb        (vb),
      .vq        (vq),
      .out_valid (fr_valid),
      .out_flags (fr_flags),
      .out_mag   (fr_mag),
      .out_sum   (fr_sum)
   );

   tsc_div3 #(
      .COORD_BITS (COORD_BITS)
   ) u_div3 (
      .clock  (clock),
      .en     (en),
      .va     (va),
      .vb     (vb),
      .vq     (vq),
      .center (center)
   );

   assign sq_side_in = {fr_flags, fr_mag[2], fr_mag[1], fr_mag[0],
                        center[2], center[1], center[0]};

   tsc_sqrt #(
      .SIDE_W (SQ_SIDE)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_sum    (fr_sum),
      .in_side   (sq_side_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   for (genvar i = 0; i < 3; i++) begin : g_mag
      assign sq_mag[i] = sq_side[CEN_W + i*MAG_BITS +: MAG_BITS];
   end

   tsc_ndiv #(
      .NORMAL_BITS (NORMAL_BITS),
      .SIDE_W      (DV_SIDE)
   ) u_ndiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_mag    (sq_mag),
      .in_root   (sq_root),
      .in_side   ({sq_side[SQ_SIDE-1 -: FLG_W], sq_side[CEN_W-1:0]}),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   assign div_flags = div_side[DV_SIDE-1 -: FLG_W];

   // Apply sign, saturate plus one, zero a degenerate face.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (div_flags.zero) begin
            nrm_in[i] = '0;
         end else if (div_flags.neg[i]) begin
            nrm_in[i] = -div_quo[i];
         end else if (div_quo[i] == NTOP) begin
            nrm_in[i] = NMAX;
         end else begin
            nrm_in[i] = div_quo[i];
         end
      end
      lhs     = {nrm_in[2], {THR_FRAC{1'b0}}};
      rhs     = {thr_ff, {(NORMAL_BITS-1){1'b0}}};
      trav_in = (lhs >= rhs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && div_valid) begin
         cen_ff  <= div_side[CEN_W-1:0];
         nrm_ff  <= nrm_in;
         trav_ff <= trav_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_center_x    = cen_ff[0*COORD_BITS +: COORD_BITS];
   assign rsp_center_y    = cen_ff[1*COORD_BITS +: COORD_BITS];
   assign rsp_center_z    = cen_ff[2*COORD_BITS +: COORD_BITS];
   assign rsp_nrm_x       = nrm_ff[0];
   assign rsp_nrm_y       = nrm_ff[1];
   assign rsp_nrm_z       = nrm_ff[2];
   assign rsp_traversable = trav_ff;

   `ASSERT_IMPLIES(a_stall_back, rsp_valid_ff && rsp_stall, req_stall, "held result did not stall input")
   `ASSERT_NEXT(a_csr_load, csr_valid && csr_ready, thr_ff == $past(csr_cos_threshold), "threshold write lost")
   `ASSERT_NEXT(a_pipe_hold, !en, $stable(div_valid), "pipeline moved while held")

endmodule
